### rtl/sorted_list_insert_remove_unit_macros.svh
// Assertion macros for the sorted list insert/remove unit.
`ifndef SORTED_LIST_INSERT_REMOVE_UNIT_MACROS_SVH
`define SORTED_LIST_INSERT_REMOVE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define SLIR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SLIR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Delayed implication, disabled while in reset.
`define SLIR_ASSERT_LAT2(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
    else $error(msg);

`endif

### rtl/slir_pkg.sv
// Shared types and constants for the sorted list insert/remove unit.
package slir_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int DATA_W       = 32;
  localparam int OP_W         = 2;
  localparam int STATUS_W     = 3;
  localparam int POS_W        = 5;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_REMOVED  = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_FULL     = 3'd3,
    ST_ENTRY    = 3'd4,
    ST_EMPTY    = 3'd5
  } status_t;

  // Broadcast control from the sequencer to every cell.
  typedef struct packed {
    logic                     cmp_en;
    logic                     ins_en;
    logic                     rem_en;
    logic                     rot_en;
    logic signed [DATA_W-1:0] value;
  } cell_ctrl_t;

endpackage

### rtl/slir_cell.sv
// One storage cell of the sorted list chain: compare flags and neighbor shifts.
module slir_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  logic                              clk,
  input  slir_pkg::cell_ctrl_t              ctrl,
  input  logic [CNT_W-1:0]                  count,
  input  logic signed [slir_pkg::DATA_W-1:0] left_data,
  input  logic                              left_ge,
  input  logic signed [slir_pkg::DATA_W-1:0] right_data,
  input  logic signed [slir_pkg::DATA_W-1:0] head_data,
  output logic signed [slir_pkg::DATA_W-1:0] data_o,
  output logic                              ge_o,
  output logic                              eq_o
);
  import slir_pkg::*;

  localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] IDX_N = CNT_W'(IDX + 1);

  logic signed [DATA_W-1:0] data_r, data_nxt;
  logic                     ge_r, ge_nxt;
  logic                     eq_r, eq_nxt;
  logic                     in_range;

  assign in_range = (IDX_C < count);

  always_comb begin
    ge_nxt   = ge_r;
    eq_nxt   = eq_r;
    data_nxt = data_r;
    if (ctrl.cmp_en) begin
      ge_nxt = in_range && (ctrl.value <= data_r);
      eq_nxt = in_range && (ctrl.value == data_r);
    end
    if (ctrl.ins_en) begin
      if (left_ge) begin
        data_nxt = left_data;
      end else if (ge_r || (IDX_C == count)) begin
        data_nxt = ctrl.value;
      end
    end else if (ctrl.rem_en) begin
      if (ge_r) begin
        data_nxt = right_data;
      end
    end else if (ctrl.rot_en) begin
      if (IDX_N == count) begin
        data_nxt = head_data;
      end else if (IDX_N < count) begin
        data_nxt = right_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    ge_r   <= ge_nxt;
    eq_r   <= eq_nxt;
  end

  assign data_o = data_r;
  assign ge_o   = ge_r;
  assign eq_o   = eq_r;

endmodule

### rtl/slir_penc.sv
// Position encoder: index of the first cell whose entry is >= the request value.
module slir_penc #(
  parameter int N     = 16,
  parameter int CNT_W = 5
) (
  input  logic [N-1:0]     ge,
  input  logic [CNT_W-1:0] count,
  output logic [CNT_W-1:0] pos
);
  logic [N-1:0]     first;
  logic [CNT_W-1:0] enc;

  assign first = ge & ~{ge[N-2:0], 1'b0};

  always_comb begin
    enc = '0;
    for (int i = 0; i < N; i++) begin
      if (first[i]) begin
        enc = enc | CNT_W'(i);
      end
    end
  end

  assign pos = (|ge) ? enc : count;

endmodule

### rtl/sorted_list_insert_remove_unit.sv
// Sorted list insert/remove unit: top level with sequencer and cell chain.
//
// Insert and remove: busy is high for one cycle after the request is taken and
// the single result strobes on out_valid in the cycle after that, so a new
// request can be taken while that result is shown. An insert into a full list
// is answered in the cycle right after the request, as is a read-out of an
// empty list. A read-out of n entries holds busy in the read state and streams
// one entry per cycle, the first one once the read state and the output register
// have been passed; the chain rotates its entries through cell 0 and is back in
// place when the last entry is out. out_valid is high for a single cycle per
// result, and the receiver cannot stall it. Operation code 3 is ignored.
module sorted_list_insert_remove_unit #(
  parameter int CAPACITY = slir_pkg::CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [slir_pkg::OP_W-1:0]           in_operation,
  input  logic signed [slir_pkg::DATA_W-1:0]  in_value,
  output logic                                out_valid,
  output logic [slir_pkg::STATUS_W-1:0]       out_status,
  output logic signed [slir_pkg::DATA_W-1:0]  out_item_value,
  output logic [slir_pkg::POS_W-1:0]          out_position,
  output logic                                out_last
);
  import slir_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_READ = 3'b100
  } state_t;

  state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [CNT_W-1:0]         rd_cnt_r, rd_cnt_nxt;
  logic [OP_W-1:0]          op_r, op_nxt;
  logic signed [DATA_W-1:0] val_r, val_nxt;

  logic                     ovalid_r, ovalid_nxt;
  logic [STATUS_W-1:0]      ostatus_r, ostatus_nxt;
  logic signed [DATA_W-1:0] oval_r, oval_nxt;
  logic [POS_W-1:0]         opos_r, opos_nxt;
  logic                     olast_r, olast_nxt;

  logic                     accept;
  logic                     found;
  logic [CNT_W-1:0]         pos;
  logic [CNT_W+POS_W-1:0]   pos_ext;
  logic [CNT_W+POS_W-1:0]   rd_ext;
  cell_ctrl_t               ctrl;

  logic signed [DATA_W-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0]      ge_vec;
  logic [CAPACITY-1:0]      eq_vec;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign found  = |eq_vec;

  assign ctrl.cmp_en = accept;
  assign ctrl.ins_en = (state_r == S_EXEC) && (op_r == OP_INSERT);
  assign ctrl.rem_en = (state_r == S_EXEC) && (op_r == OP_REMOVE) && found;
  assign ctrl.rot_en = (state_r == S_READ);
  assign ctrl.value  = busy ? val_r : in_value;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [DATA_W-1:0] left_d;
    logic signed [DATA_W-1:0] right_d;
    logic                     left_g;

    if (g == 0) begin : g_first
      assign left_d = in_value;
      assign left_g = 1'b0;
    end else begin : g_mid
      assign left_d = cell_data[g-1];
      assign left_g = ge_vec[g-1];
    end

    if (g == CAPACITY - 1) begin : g_end
      assign right_d = cell_data[g];
    end else begin : g_inner
      assign right_d = cell_data[g+1];
    end

    slir_cell #(
      .IDX   (g),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .count      (count_r),
      .left_data  (left_d),
      .left_ge    (left_g),
      .right_data (right_d),
      .head_data  (cell_data[0]),
      .data_o     (cell_data[g]),
      .ge_o       (ge_vec[g]),
      .eq_o       (eq_vec[g])
    );
  end

  slir_penc #(
    .N     (CAPACITY),
    .CNT_W (CNT_W)
  ) u_penc (
    .ge    (ge_vec),
    .count (count_r),
    .pos   (pos)
  );

  assign pos_ext = {{POS_W{1'b0}}, pos};
  assign rd_ext  = {{POS_W{1'b0}}, rd_cnt_r};

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    rd_cnt_nxt  = rd_cnt_r;
    op_nxt      = op_r;
    val_nxt     = val_r;
    ovalid_nxt  = 1'b0;
    ostatus_nxt = ostatus_r;
    oval_nxt    = oval_r;
    opos_nxt    = opos_r;
    olast_nxt   = olast_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt  = in_operation;
          val_nxt = in_value;
          case (in_operation)
            OP_INSERT: begin
              if (count_r == CNT_FULL) begin
                ovalid_nxt  = 1'b1;
                ostatus_nxt = ST_FULL;
                oval_nxt    = in_value;
                opos_nxt    = '0;
                olast_nxt   = 1'b1;
              end else begin
                state_nxt = S_EXEC;
              end
            end
            OP_REMOVE: begin
              state_nxt = S_EXEC;
            end
            OP_READ: begin
              if (count_r == '0) begin
                ovalid_nxt  = 1'b1;
                ostatus_nxt = ST_EMPTY;
                oval_nxt    = '0;
                opos_nxt    = '0;
                olast_nxt   = 1'b1;
              end else begin
                rd_cnt_nxt = '0;
                state_nxt  = S_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_EXEC: begin
        ovalid_nxt = 1'b1;
        oval_nxt   = val_r;
        olast_nxt  = 1'b1;
        state_nxt  = S_IDLE;
        if (op_r == OP_INSERT) begin
          ostatus_nxt = ST_INSERTED;
          opos_nxt    = pos_ext[POS_W-1:0];
          count_nxt   = count_r + CNT_ONE;
        end else if (found) begin
          ostatus_nxt = ST_REMOVED;
          opos_nxt    = pos_ext[POS_W-1:0];
          count_nxt   = count_r - CNT_ONE;
        end else begin
          ostatus_nxt = ST_NOTFOUND;
          opos_nxt    = '0;
        end
      end
      S_READ: begin
        ovalid_nxt  = 1'b1;
        ostatus_nxt = ST_ENTRY;
        oval_nxt    = cell_data[0];
        opos_nxt    = rd_ext[POS_W-1:0];
        olast_nxt   = ((rd_cnt_r + CNT_ONE) == count_r);
        rd_cnt_nxt  = rd_cnt_r + CNT_ONE;
        if ((rd_cnt_r + CNT_ONE) == count_r) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_cnt_r  <= rd_cnt_nxt;
    op_r      <= op_nxt;
    val_r     <= val_nxt;
    ostatus_r <= ostatus_nxt;
    oval_r    <= oval_nxt;
    opos_r    <= opos_nxt;
    olast_r   <= olast_nxt;
  end

  assign out_valid      = ovalid_r;
  assign out_status     = ostatus_r;
  assign out_item_value = oval_r;
  assign out_position   = opos_r;
  assign out_last       = olast_r;

endmodule

### rtl/slir_chk.sv
// Port-level checker for the sorted list insert/remove unit, with its bind.
`include "sorted_list_insert_remove_unit_macros.svh"

module slir_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic [slir_pkg::OP_W-1:0]     in_operation,
  input logic                          out_valid,
  input logic [slir_pkg::STATUS_W-1:0] out_status,
  input logic                          out_last
);
  import slir_pkg::*;

  `SLIR_ASSERT_LAT2(a_rem_result, clk, rst_n, start && !busy && (in_operation == OP_REMOVE), out_valid && out_last && ((out_status == ST_REMOVED) || (out_status == ST_NOTFOUND)), "remove request did not give one result two cycles later")
  `SLIR_ASSERT_NOW(a_single_last, clk, rst_n, out_valid && (out_status != ST_ENTRY), out_last, "non-entry result not marked last")
  `SLIR_ASSERT_NEXT(a_stream_cont, clk, rst_n, out_valid && !out_last, out_valid && (out_status == ST_ENTRY), "read-out stream broken")
  `SLIR_ASSERT_NOW(a_busy_stream, clk, rst_n, out_valid && !out_last, busy, "unit idle while read-out still running")

endmodule

bind sorted_list_insert_remove_unit slir_chk u_slir_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .in_operation (in_operation),
  .out_valid    (out_valid),
  .out_status   (out_status),
  .out_last     (out_last)
);

### tb/sv/tb_sorted_list_insert_remove_unit.sv
// Testbench for the sorted list insert/remove unit: random and directed requests against a list predictor.
`timescale 1ns / 100ps

typedef struct {
  logic [slir_pkg::STATUS_W-1:0]      status;
  logic signed [slir_pkg::DATA_W-1:0] item_value;
  logic [slir_pkg::POS_W-1:0]         position;
  logic                               last;
} list_result_t;

class list_scoreboard;
  localparam int DEPTH = slir_pkg::CAPACITY_DEF;

  logic signed [slir_pkg::DATA_W-1:0] entries [DEPTH];
  int unsigned                        count;
  list_result_t                       pending [$];
  int unsigned                        errors;

  function new();
    count  = 0;
    errors = 0;
  endfunction

  function void push_result(logic [slir_pkg::STATUS_W-1:0] status,
                            logic signed [slir_pkg::DATA_W-1:0] v,
                            int unsigned pos, logic last);
    list_result_t r;
    r.status     = status;
    r.item_value = v;
    r.position   = pos[slir_pkg::POS_W-1:0];
    r.last       = last;
    pending.push_back(r);
  endfunction

  function logic signed [slir_pkg::DATA_W-1:0] pick_stored();
    return entries[$urandom_range(count - 1)];
  endfunction

  // Update the list for one accepted request and queue the results it causes.
  function void note_request(logic [slir_pkg::OP_W-1:0] op,
                             logic signed [slir_pkg::DATA_W-1:0] v);
    int unsigned slot;
    int unsigned k;
    case (op)
      slir_pkg::OP_INSERT: begin
        if (count >= DEPTH) begin
          push_result(slir_pkg::ST_FULL, v, 0, 1'b1);
        end else begin
          slot = count;
          for (k = 0; k < count; k++) begin
            if (v <= entries[k]) begin
              slot = k;
              break;
            end
          end
          for (k = count; k > slot; k--) entries[k] = entries[k-1];
          entries[slot] = v;
          count++;
          push_result(slir_pkg::ST_INSERTED, v, slot, 1'b1);
        end
      end
      slir_pkg::OP_REMOVE: begin
        slot = count;
        for (k = 0; k < count; k++) begin
          if (entries[k] == v) begin
            slot = k;
            break;
          end
        end
        if (slot == count) begin
          push_result(slir_pkg::ST_NOTFOUND, v, 0, 1'b1);
        end else begin
          for (k = slot; k + 1 < count; k++) entries[k] = entries[k+1];
          count--;
          push_result(slir_pkg::ST_REMOVED, v, slot, 1'b1);
        end
      end
      slir_pkg::OP_READ: begin
        if (count == 0) begin
          push_result(slir_pkg::ST_EMPTY, '0, 0, 1'b1);
        end else begin
          for (k = 0; k < count; k++)
            push_result(slir_pkg::ST_ENTRY, entries[k], k, k + 1 == count);
        end
      end
      default: ;
    endcase
  endfunction

  task report_mismatch(string what);
    errors++;
    if (errors <= 100) $display("MISMATCH at %0t: %s", $time, what);
  endtask

  task check_result(logic [slir_pkg::STATUS_W-1:0] status,
                    logic signed [slir_pkg::DATA_W-1:0] v,
                    logic [slir_pkg::POS_W-1:0] pos, logic last);
    list_result_t exp;
    if (pending.size() == 0) begin
      report_mismatch($sformatf("unexpected result status=%0d value=%0d pos=%0d",
                                status, v, pos));
    end else begin
      exp = pending.pop_front();
      if (status !== exp.status)
        report_mismatch($sformatf("status %0d, expected %0d", status, exp.status));
      if (v !== exp.item_value)
        report_mismatch($sformatf("item_value %0d, expected %0d", v, exp.item_value));
      if (pos !== exp.position)
        report_mismatch($sformatf("position %0d, expected %0d", pos, exp.position));
      if (last !== exp.last)
        report_mismatch($sformatf("last %0b, expected %0b", last, exp.last));
    end
  endtask
endclass

module tb_sorted_list_insert_remove_unit;
  import slir_pkg::*;

  localparam int                CAP         = CAPACITY_DEF;
  localparam int                CYCLE_LIMIT = 400000;
  localparam int                PHASE_ITEMS = 100;
  localparam logic [OP_W-1:0]   OP_IGNORED  = 2'd3;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       start = 1'b0;
  logic [OP_W-1:0]            in_operation = '0;
  logic signed [DATA_W-1:0]   in_value = '0;
  logic                       busy;
  logic                       out_valid;
  logic [STATUS_W-1:0]        out_status;
  logic signed [DATA_W-1:0]   out_item_value;
  logic [POS_W-1:0]           out_position;
  logic                       out_last;

  list_scoreboard sb = new();
  int unsigned    cycle_count = 0;
  int unsigned    idle_pct = 0;
  bit             fill_mode = 1'b1;

  sorted_list_insert_remove_unit #(.CAPACITY(CAP)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_operation   (in_operation),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_item_value (out_item_value),
    .out_position   (out_position),
    .out_last       (out_last)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_result(out_status, out_item_value, out_position, out_last);
      if (start && !busy) sb.note_request(in_operation, in_value);
    end
  end

  function automatic logic signed [DATA_W-1:0] rand_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 30) return int'($urandom_range(8)) - 4;
    if (r < 40) begin
      case ($urandom_range(3))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return -32'sd1;
        default: return '0;
      endcase
    end
    return $urandom();
  endfunction

  task automatic idle_gap();
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // Called at a falling edge; holds the request until it is taken.
  task automatic drive(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] v);
    start        <= 1'b1;
    in_operation <= op;
    in_value     <= v;
    do @(posedge clk); while (busy);
  endtask

  task automatic send_req(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] v);
    idle_gap();
    @(negedge clk);
    drive(op, v);
  endtask

  task automatic send_random();
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] v;
    int unsigned              r;
    idle_gap();
    @(negedge clk);
    if (sb.count >= CAP) fill_mode = 1'b0;
    else if (sb.count == 0) fill_mode = 1'b1;
    r = $urandom_range(99);
    v = rand_value();
    if (r < 5) begin
      op = OP_IGNORED;
      v  = $urandom();
    end else if (r < 20) begin
      op = OP_READ;
      v  = $urandom();
    end else if (($urandom_range(99) < 70) == fill_mode) begin
      op = OP_INSERT;
    end else begin
      op = OP_REMOVE;
      if (sb.count > 0 && $urandom_range(99) < 80) v = sb.pick_stored();
    end
    drive(op, v);
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    send_req(OP_READ, 32'sd0);
    send_req(OP_REMOVE, 32'sd7);
    send_req(OP_INSERT, 32'sh7fff_ffff);
    send_req(OP_INSERT, 32'sh8000_0000);
    send_req(OP_INSERT, -32'sd1);
    send_req(OP_INSERT, 32'sd0);
    send_req(OP_INSERT, 32'sd0);
    send_req(OP_INSERT, 32'sd1);
    send_req(OP_READ, 32'sd0);
    send_req(OP_REMOVE, 32'sh8000_0000);
    send_req(OP_REMOVE, 32'sh7fff_ffff);
    send_req(OP_REMOVE, 32'sd0);
    send_req(OP_REMOVE, 32'sd5);
    send_req(OP_IGNORED, 32'sd0);
    // three entries left; fill up, then hit the full list
    for (int k = 0; k < CAP - 3; k++) send_req(OP_INSERT, $urandom());
    send_req(OP_INSERT, 32'sd42);
    send_req(OP_READ, 32'sd0);

    idle_pct = 9;
    for (int n = 0; n < PHASE_ITEMS; n++) send_random();
    idle_pct = 86;
    for (int n = 0; n < PHASE_ITEMS; n++) send_random();
    idle_pct = 0;
    for (int n = 0; n < PHASE_ITEMS; n++) send_random();

    @(negedge clk);
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (CAP + 4) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

### files.f
+incdir+rtl
rtl/slir_pkg.sv
rtl/slir_cell.sv
rtl/slir_penc.sv
rtl/sorted_list_insert_remove_unit.sv
rtl/slir_chk.sv
tb/sv/tb_sorted_list_insert_remove_unit.sv
